>>> rtl/lru_pkg.sv
// Shared constants and types for the LRU page replacement core.
`default_nettype none

package lru_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    localparam int PAGE_W  = 16;        // page field width on the ports
    localparam int FRAME_W = 3;         // frame field width on the ports
    localparam int CFG_W   = 4;
    localparam int TOTAL_W = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // engine status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
        logic ev_valid;
    } t_eng_stat;

endpackage

`default_nettype wire

>>> rtl/lru_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lru_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/lru_engine.sv
// Replacement engine: frame table in RAM, scan pass then read-modify-write aging pass.
`default_nettype none

module lru_engine #(
    parameter  int FRAMES    = lru_pkg::FRAMES_DEF,
    parameter  int PAGE_BITS = lru_pkg::PAGE_BITS_DEF,
    localparam int FIDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int CNT_W     = $clog2(FRAMES + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [PAGE_BITS-1:0] i_page,
    input  wire logic [CNT_W-1:0]     i_n_act,
    input  wire logic                 i_ack,
    output lru_pkg::t_eng_stat        o_stat,
    output logic      [FIDX_W-1:0]    o_frame,
    output logic      [PAGE_BITS-1:0] o_ev_page
);

    localparam int RANK_W = FIDX_W;
    localparam int DW     = PAGE_BITS + RANK_W;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);
    localparam logic [CNT_W-1:0]  CNT_FRAMES = CNT_W'(FRAMES);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_UPD    = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_rv, n_rv;
    logic [FIDX_W-1:0]     r_ridx, n_ridx;
    logic [FRAMES-1:0]     r_valid, n_valid;
    logic [PAGE_BITS-1:0]  r_page, n_page;
    logic                  r_hit, n_hit;
    logic [FIDX_W-1:0]     r_match_idx, n_match_idx;
    logic [RANK_W-1:0]     r_match_rank, n_match_rank;
    logic                  r_empty_found, n_empty_found;
    logic [FIDX_W-1:0]     r_empty_idx, n_empty_idx;
    logic [RANK_W-1:0]     r_best_rank, n_best_rank;
    logic [FIDX_W-1:0]     r_best_idx, n_best_idx;
    logic [PAGE_BITS-1:0]  r_best_page, n_best_page;
    logic [FIDX_W-1:0]     r_f, n_f;
    logic                  r_wv, n_wv;
    logic [RANK_W-1:0]     r_old, n_old;
    logic [PAGE_BITS-1:0]  r_ev_page, n_ev_page;

    logic                  ram_we, ram_re;
    logic [FIDX_W-1:0]     ram_waddr, ram_raddr;
    logic [DW-1:0]         ram_wdata, ram_rdata;
    logic [PAGE_BITS-1:0]  rd_page;
    logic [RANK_W-1:0]     rd_rank;
    logic                  rd_valid;
    logic [CNT_W-1:0]      n_act_m1;
    logic [FIDX_W-1:0]     last_act;

    assign rd_page  = ram_rdata[DW-1:RANK_W];
    assign rd_rank  = ram_rdata[RANK_W-1:0];
    assign rd_valid = r_valid[r_ridx];
    assign n_act_m1 = i_n_act - CNT_W'(1);
    assign last_act = n_act_m1[FIDX_W-1:0];

    lru_ram #(
        .WIDTH (DW),
        .DEPTH (FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_rv          = 1'b0;
        n_ridx        = r_ridx;
        n_valid       = r_valid;
        n_page        = r_page;
        n_hit         = r_hit;
        n_match_idx   = r_match_idx;
        n_match_rank  = r_match_rank;
        n_empty_found = r_empty_found;
        n_empty_idx   = r_empty_idx;
        n_best_rank   = r_best_rank;
        n_best_idx    = r_best_idx;
        n_best_page   = r_best_page;
        n_f           = r_f;
        n_wv          = r_wv;
        n_old         = r_old;
        n_ev_page     = r_ev_page;
        ram_re        = 1'b0;
        ram_raddr     = r_cnt[FIDX_W-1:0];
        ram_we        = 1'b0;
        ram_waddr     = r_ridx;
        ram_wdata     = ram_rdata;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_page        = i_page;
                    n_hit         = 1'b0;
                    n_empty_found = 1'b0;
                    ram_re        = 1'b1;
                    ram_raddr     = '0;
                    n_cnt         = CNT_W'(1);
                    n_rv          = 1'b1;
                    n_ridx        = '0;
                    n_state       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt < i_n_act) begin
                    ram_re = 1'b1;
                    n_cnt  = r_cnt + CNT_W'(1);
                    n_rv   = 1'b1;
                    n_ridx = r_cnt[FIDX_W-1:0];
                end
                if (r_rv) begin
                    if (rd_valid && rd_page == r_page && !r_hit) begin
                        n_hit        = 1'b1;
                        n_match_idx  = r_ridx;
                        n_match_rank = rd_rank;
                    end
                    if (!rd_valid && !r_empty_found) begin
                        n_empty_found = 1'b1;
                        n_empty_idx   = r_ridx;
                    end
                    // strict compare keeps the lowest index among equal ranks
                    if (r_ridx == '0 || rd_rank > r_best_rank) begin
                        n_best_rank = rd_rank;
                        n_best_idx  = r_ridx;
                        n_best_page = rd_page;
                    end
                    if (r_ridx == last_act) begin
                        n_state = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (r_hit) begin
                    n_f   = r_match_idx;
                    n_wv  = 1'b1;
                    n_old = r_match_rank;
                end else if (r_empty_found) begin
                    n_f   = r_empty_idx;
                    n_wv  = 1'b0;
                    n_old = '0;
                end else begin
                    n_f   = r_best_idx;
                    n_wv  = 1'b1;
                    n_old = r_best_rank;
                end
                n_ev_page = (!r_hit && !r_empty_found) ? r_best_page : '0;
                ram_re    = 1'b1;
                ram_raddr = '0;
                n_cnt     = CNT_W'(1);
                n_rv      = 1'b1;
                n_ridx    = '0;
                n_state   = ST_UPD;
            end
            ST_UPD: begin
                // read of entry k+1 overlaps the write of entry k: never the same entry
                if (r_cnt < CNT_FRAMES) begin
                    ram_re = 1'b1;
                    n_cnt  = r_cnt + CNT_W'(1);
                    n_rv   = 1'b1;
                    n_ridx = r_cnt[FIDX_W-1:0];
                end
                if (r_rv) begin
                    ram_we = 1'b1;
                    if (r_ridx == r_f) begin
                        ram_wdata = {(r_hit ? rd_page : r_page), {RANK_W{1'b0}}};
                    end else if (rd_valid && (!r_wv || rd_rank < r_old)
                                 && rd_rank != RANK_MAX) begin
                        ram_wdata = {rd_page, rd_rank + RANK_W'(1)};
                    end
                    if (r_ridx == FIDX_W'(FRAMES - 1)) begin
                        n_valid[r_f] = 1'b1;
                        n_state      = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (i_ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rv    <= 1'b0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_rv    <= n_rv;
            r_valid <= n_valid;
        end
        r_cnt         <= n_cnt;
        r_ridx        <= n_ridx;
        r_page        <= n_page;
        r_hit         <= n_hit;
        r_match_idx   <= n_match_idx;
        r_match_rank  <= n_match_rank;
        r_empty_found <= n_empty_found;
        r_empty_idx   <= n_empty_idx;
        r_best_rank   <= n_best_rank;
        r_best_idx    <= n_best_idx;
        r_best_page   <= n_best_page;
        r_f           <= n_f;
        r_wv          <= n_wv;
        r_old         <= n_old;
        r_ev_page     <= n_ev_page;
    end

    assign o_stat.busy     = (r_state != ST_IDLE);
    assign o_stat.done     = (r_state == ST_DONE);
    assign o_stat.hit      = r_hit;
    assign o_stat.ev_valid = !r_hit && r_wv;
    assign o_frame         = r_f;
    assign o_ev_page       = r_ev_page;

    a_used_frame_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> r_valid[r_f])
        else $error("frame used by the word is not marked valid");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && ram_re) |-> (r_cnt < i_n_act))
        else $error("scan read beyond the active frames");

    a_idle_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_rv)
        else $error("read data pending while idle");

    a_fill_only_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD && !r_wv) |-> !r_valid[r_f])
        else $error("fill targets a frame that is already valid");

endmodule

`default_nettype wire

>>> rtl/lru_page_replacement_core.sv
// Each word runs a scan pass over the n_active active frames, then an aging pass over all
// frames, through the single frame-table RAM; n_active is frames_in_use clamped to 1..FRAMES.
// No new word is taken until the result of the last one has moved to the output register,
// which holds that result while the output stalls.
// Reset (synchronous, active low): all frames empty, totals zero, frames_in_use = 8;
// the frame-table RAM is not cleared; an entry's contents take effect only once its frame is valid.
`default_nettype none

module lru_page_replacement_core #(
    parameter int FRAMES    = lru_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [lru_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [lru_pkg::PAGE_W-1:0]   i_page,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_hit,
    output logic      [lru_pkg::FRAME_W-1:0]  o_frame,
    output logic                              o_evicted_valid,
    output logic      [lru_pkg::PAGE_W-1:0]   o_evicted_page,
    output logic      [lru_pkg::TOTAL_W-1:0]  o_hit_total,
    output logic      [lru_pkg::TOTAL_W-1:0]  o_access_total
);

    localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int AW     = (CNT_W > lru_pkg::CFG_W) ? CNT_W : lru_pkg::CFG_W;
    localparam int PW     = lru_pkg::PAGE_W;
    localparam int FW     = lru_pkg::FRAME_W;
    localparam int TW     = lru_pkg::TOTAL_W;

    logic [lru_pkg::CFG_W-1:0] r_cfg;
    logic [AW-1:0]             cfg_ext;
    logic [AW-1:0]             n_act_ext;
    logic [CNT_W-1:0]          n_act;

    logic [PAGE_BITS-1:0]      page_in;
    logic [PAGE_BITS-1:0]      eng_ev_page;
    logic [FIDX_W-1:0]         eng_frame;
    lru_pkg::t_eng_stat        eng_stat;
    logic                      start, ack;
    logic [FW-1:0]             frame_out;
    logic [PW-1:0]             ev_page_out;

    logic                      r_out_valid;
    logic                      r_hit;
    logic [FW-1:0]             r_frame;
    logic                      r_ev_valid;
    logic [PW-1:0]             r_ev_page;
    logic [TW-1:0]             r_hit_total, n_hit_total;
    logic [TW-1:0]             r_acc_total, n_acc_total;

    // active frame count, clamped to 1..FRAMES
    assign cfg_ext = AW'(r_cfg);
    always_comb begin
        if (cfg_ext == '0) begin
            n_act_ext = AW'(1);
        end else if (cfg_ext > AW'(FRAMES)) begin
            n_act_ext = AW'(FRAMES);
        end else begin
            n_act_ext = cfg_ext;
        end
    end
    assign n_act = n_act_ext[CNT_W-1:0];

    generate
        if (PAGE_BITS <= PW) begin : g_page_narrow
            assign page_in     = i_page[PAGE_BITS-1:0];
            assign ev_page_out = PW'(eng_ev_page);
        end else begin : g_page_wide
            assign page_in     = PAGE_BITS'(i_page);
            assign ev_page_out = eng_ev_page[PW-1:0];
        end
        if (FIDX_W >= FW) begin : g_frame_trunc
            assign frame_out = eng_frame[FW-1:0];
        end else begin : g_frame_ext
            assign frame_out = FW'(eng_frame);
        end
    endgenerate

    assign o_in_stall = eng_stat.busy;
    assign start      = i_in_valid && !eng_stat.busy;
    assign ack        = eng_stat.done && (!r_out_valid || !i_out_stall);

    lru_engine #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_page    (page_in),
        .i_n_act   (n_act),
        .i_ack     (ack),
        .o_stat    (eng_stat),
        .o_frame   (eng_frame),
        .o_ev_page (eng_ev_page)
    );

    assign n_acc_total = (r_acc_total == lru_pkg::TOTAL_MAX) ? r_acc_total
                                                              : r_acc_total + TW'(1);
    assign n_hit_total = (!eng_stat.hit || r_hit_total == lru_pkg::TOTAL_MAX) ? r_hit_total
                                                              : r_hit_total + TW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= lru_pkg::CFG_RESET;
            r_out_valid <= 1'b0;
            r_hit_total <= '0;
            r_acc_total <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (ack) begin
                r_out_valid <= 1'b1;
                r_hit_total <= n_hit_total;
                r_acc_total <= n_acc_total;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (ack) begin
            r_hit      <= eng_stat.hit;
            r_frame    <= frame_out;
            r_ev_valid <= eng_stat.ev_valid;
            r_ev_page  <= ev_page_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_frame         = r_frame;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_hit_total     = r_hit_total;
    assign o_access_total  = r_acc_total;

    a_hits_le_accesses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit_total <= r_acc_total)
        else $error("hit total exceeds access total");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_hit) |-> !r_ev_valid)
        else $error("eviction reported on a hit");

    a_no_evict_zero_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_ev_valid) |-> (r_ev_page == '0))
        else $error("evicted page nonzero without eviction");

endmodule

`default_nettype wire

>>> dv/lru_lookup_checker.sv
// Checker for the LRU page replacement core: tracks the frame table and compares every result.
`default_nettype none

module lru_lookup_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [lru_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_stall,
    input  wire logic [lru_pkg::PAGE_W-1:0]  i_page,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_stall,
    input  wire logic                        i_hit,
    input  wire logic [lru_pkg::FRAME_W-1:0] i_frame,
    input  wire logic                        i_evicted_valid,
    input  wire logic [lru_pkg::PAGE_W-1:0]  i_evicted_page,
    input  wire logic [lru_pkg::TOTAL_W-1:0] i_hit_total,
    input  wire logic [lru_pkg::TOTAL_W-1:0] i_access_total,
    output int                               o_errors,
    output int                               o_results,
    output int                               o_outstanding
);

    localparam int FRAMES   = lru_pkg::FRAMES_DEF;
    localparam int RANK_TOP = FRAMES - 1;

    typedef struct packed {
        logic                        hit;
        logic [lru_pkg::FRAME_W-1:0] frame;
        logic                        ev_valid;
        logic [lru_pkg::PAGE_W-1:0]  ev_page;
        logic [lru_pkg::TOTAL_W-1:0] hit_total;
        logic [lru_pkg::TOTAL_W-1:0] access_total;
    } t_lookup;

    logic [lru_pkg::PAGE_W-1:0]  slot_page [FRAMES];
    logic                        slot_full [FRAMES];
    logic [2:0]                  slot_age  [FRAMES];
    logic [lru_pkg::TOTAL_W-1:0] hit_cnt;
    logic [lru_pkg::TOTAL_W-1:0] access_cnt;
    logic [lru_pkg::CFG_W-1:0]   frames_cfg;

    t_lookup pending_lookups [$];
    int      err_cnt;
    int      result_cnt;

    task automatic report_error(input string msg);
        begin
            if (err_cnt < 100)
                $display("%0t: bad lookup: %s", $time, msg);
            err_cnt++;
        end
    endtask

    // Touched frame goes to age 0; others younger than it (or all, on a fill) grow older.
    task automatic make_recent(input int f, input bit was_full);
        logic [2:0] old_age;
        begin
            old_age = slot_age[f];
            for (int i = 0; i < FRAMES; i++) begin
                if (i != f && slot_full[i] && (!was_full || slot_age[i] < old_age)) begin
                    if (slot_age[i] != RANK_TOP[2:0])
                        slot_age[i] = slot_age[i] + 3'd1;
                end
            end
            slot_age[f] = '0;
        end
    endtask

    task automatic predict_lookup(input logic [lru_pkg::PAGE_W-1:0] page);
        int         n;
        int         f;
        bit         found;
        bit         empty_found;
        logic [2:0] oldest;
        t_lookup    r;
        begin
            n = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
            r = '0;
            f = 0;
            found = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!found && slot_full[i] && slot_page[i] == page) begin
                    f = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                make_recent(f, 1'b1);
            end else begin
                empty_found = 1'b0;
                for (int i = 0; i < n; i++) begin
                    if (!empty_found && !slot_full[i]) begin
                        f = i;
                        empty_found = 1'b1;
                    end
                end
                if (empty_found) begin
                    make_recent(f, 1'b0);
                    slot_full[f] = 1'b1;
                end else begin
                    // lowest index wins a tie on age
                    f = 0;
                    oldest = slot_age[0];
                    for (int i = 1; i < n; i++) begin
                        if (slot_age[i] > oldest) begin
                            oldest = slot_age[i];
                            f = i;
                        end
                    end
                    r.ev_valid = 1'b1;
                    r.ev_page  = slot_page[f];
                    make_recent(f, 1'b1);
                end
                slot_page[f] = page;
            end
            if (access_cnt != lru_pkg::TOTAL_MAX)
                access_cnt = access_cnt + 1;
            if (found && hit_cnt != lru_pkg::TOTAL_MAX)
                hit_cnt = hit_cnt + 1;
            r.hit          = found;
            r.frame        = f[lru_pkg::FRAME_W-1:0];
            r.hit_total    = hit_cnt;
            r.access_total = access_cnt;
            pending_lookups.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_lookup exp_r;
        t_lookup got_r;
        if (!i_rst_n) begin
            for (int i = 0; i < FRAMES; i++) begin
                slot_page[i] = '0;
                slot_full[i] = 1'b0;
                slot_age[i]  = '0;
            end
            hit_cnt    = '0;
            access_cnt = '0;
            frames_cfg = lru_pkg::CFG_RESET;
            pending_lookups.delete();
        end else begin
            if (i_cfg_we)
                frames_cfg = i_cfg_wdata;
            // a result leaving now belongs to an earlier word, so check before predicting
            if (i_out_valid && !i_out_stall) begin
                result_cnt++;
                got_r.hit          = i_hit;
                got_r.frame        = i_frame;
                got_r.ev_valid     = i_evicted_valid;
                got_r.ev_page      = i_evicted_page;
                got_r.hit_total    = i_hit_total;
                got_r.access_total = i_access_total;
                if (pending_lookups.size() == 0) begin
                    report_error($sformatf("result with nothing pending hit=%0b frame=%0d",
                                           got_r.hit, got_r.frame));
                end else begin
                    exp_r = pending_lookups.pop_front();
                    if (got_r.hit !== exp_r.hit || got_r.frame !== exp_r.frame ||
                        got_r.ev_valid !== exp_r.ev_valid || got_r.ev_page !== exp_r.ev_page ||
                        got_r.hit_total !== exp_r.hit_total ||
                        got_r.access_total !== exp_r.access_total)
                        report_error($sformatf(
                            "hit %0b/%0b frame %0d/%0d ev %0b/%0b evpage %h/%h tot %0d/%0d acc %0d/%0d",
                            exp_r.hit, got_r.hit, exp_r.frame, got_r.frame,
                            exp_r.ev_valid, got_r.ev_valid, exp_r.ev_page, got_r.ev_page,
                            exp_r.hit_total, got_r.hit_total,
                            exp_r.access_total, got_r.access_total));
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_lookup(i_page);
        end
        o_errors      <= err_cnt;
        o_results     <= result_cnt;
        o_outstanding <= pending_lookups.size();
    end

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench top for the LRU page replacement core: stimulus, idling and verdict.
`default_nettype none

module tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 24;   // extra wait after the last result before the verdict

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [lru_pkg::CFG_W-1:0]   i_cfg_wdata = '0;
    logic                        i_in_valid = 1'b0;
    logic [lru_pkg::PAGE_W-1:0]  i_page = '0;
    logic                        i_out_stall = 1'b0;
    logic                        o_in_stall;
    logic                        o_out_valid;
    logic                        o_hit;
    logic [lru_pkg::FRAME_W-1:0] o_frame;
    logic                        o_evicted_valid;
    logic [lru_pkg::PAGE_W-1:0]  o_evicted_page;
    logic [lru_pkg::TOTAL_W-1:0] o_hit_total;
    logic [lru_pkg::TOTAL_W-1:0] o_access_total;

    int errors;
    int results;
    int outstanding;
    int words_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    logic [lru_pkg::PAGE_W-1:0] page_pool [16];

    always #5 i_clk = ~i_clk;

    lru_page_replacement_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_page          (i_page),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit           (o_hit),
        .o_frame         (o_frame),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_hit_total     (o_hit_total),
        .o_access_total  (o_access_total)
    );

    lru_lookup_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_page          (i_page),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_hit           (o_hit),
        .i_frame         (o_frame),
        .i_evicted_valid (o_evicted_valid),
        .i_evicted_page  (o_evicted_page),
        .i_hit_total     (o_hit_total),
        .i_access_total  (o_access_total),
        .o_errors        (errors),
        .o_results       (results),
        .o_outstanding   (outstanding)
    );

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("lru_page_replacement_core: mismatch");
            $finish;
        end
    end

    // Called on a clock edge; returns on the edge where the word is taken.
    task automatic send_word(input logic [lru_pkg::PAGE_W-1:0] p);
        begin
            while ($urandom_range(99) < send_idle_pct) begin
                i_in_valid <= 1'b0;
                i_page     <= 16'($urandom);
                @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_page     <= p;
            do @(posedge i_clk); while (o_in_stall);
            words_sent++;
        end
    endtask

    task automatic wait_drained();
        begin
            i_in_valid <= 1'b0;
            while (results < words_sent)
                @(posedge i_clk);
        end
    endtask

    task automatic set_frames(input logic [lru_pkg::CFG_W-1:0] v);
        begin
            wait_drained();
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= v;
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;
        end
    endtask

    initial begin
        logic [lru_pkg::CFG_W-1:0] phase_frames [9];
        int                        n_active;
        int                        span;
        int                        sel;
        logic [lru_pkg::PAGE_W-1:0] p;

        // extremes and out-of-range register values, shrinking and growing between phases
        phase_frames = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd6, 4'd2, 4'd12, 4'd5};
        foreach (page_pool[i])
            page_pool[i] = 16'($urandom);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, hits, filling every frame, then LRU evictions
        set_frames(4'd8);
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h0001);
        send_word(16'h0002);
        send_word(16'h0004);
        send_word(16'h0008);
        send_word(16'h0010);
        send_word(16'h0020);
        send_word(16'h8000);   // table full: oldest frame goes
        send_word(16'h0000);
        send_word(16'h0020);
        send_word(16'hAAAA);
        send_word(16'h5555);
        send_word(16'h5555);
        send_word(16'h8000);
        send_word(16'h0001);

        for (int ph = 0; ph < 9; ph++) begin
            set_frames(phase_frames[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            // refresh part of the working set so stale pages linger in inactive frames
            repeat (4) page_pool[$urandom_range(15)] = 16'($urandom);
            n_active = (phase_frames[ph] == 0) ? 1 :
                       ((phase_frames[ph] > 8) ? 8 : int'(phase_frames[ph]));
            for (int j = 0; j < 105; j++) begin
                span = n_active + $urandom_range(3);
                sel  = $urandom_range(99);
                if (sel < 70)
                    p = page_pool[$urandom_range(span - 1)];
                else if (sel < 90)
                    p = page_pool[$urandom_range(15)];
                else
                    p = 16'($urandom);
                send_word(p);
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0 && outstanding == 0)
            $display("lru_page_replacement_core: match");
        else
            $display("lru_page_replacement_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
